### hw/rtl/cdn_pkg.sv
package cdn_pkg;

   typedef logic signed [14:0] year_type;
   typedef logic [3:0]         month_type;
   typedef logic [4:0]         dom_type;
   typedef logic [4:0]         hour_type;
   typedef logic [5:0]         minute_type;
   typedef logic [5:0]         second_type;
   typedef logic signed [22:0] whole_days_type;
   typedef logic [16:0]        day_seconds_type;

   typedef struct packed {
      year_type   year;
      month_type  month;
      dom_type    day_of_month;
      hour_type   hour;
      minute_type minute;
      second_type second;
   } date_type;

   typedef struct packed {
      whole_days_type  whole_days;
      day_seconds_type day_seconds;
   } result_type;

   localparam logic [16:0]        SecondsPerDay  = 17'd86400;
   localparam logic [16:0]        SecondsPerHour = 17'd3600;
   localparam logic [16:0]        SecondsPerMin  = 17'd60;
   localparam logic signed [26:0] EpochOffset    = 27'sd694025;
   localparam logic signed [26:0] WholeDaysMax   = 27'sd4194303;
   localparam logic signed [26:0] WholeDaysMin   = -27'sd4194304;
   localparam logic signed [14:0] GregorianYear  = 15'sd1582;
   localparam month_type          GregorianMonth = 4'd10;
   localparam logic [5:0]         GregorianDay   = 6'd15;
   localparam month_type          MonthMarch     = 4'd3;
   // 1461/4 days per year, 1/100 via 5243/2^19
   localparam logic signed [26:0] QuarterDaysPerYear = 27'sd1461;
   localparam logic [12:0]        CenturyRecip       = 13'd5243;
   localparam int                 CenturyShift       = 19;

   // floor(30.6001 * (m + 1)); Jan/Feb map to months 13 and 14, month zero to month 12
   function automatic logic [8:0] month_days(input month_type month);
      logic [8:0] days;
      unique case (month)
         4'd0:    days = 9'd397;
         4'd1:    days = 9'd428;
         4'd2:    days = 9'd459;
         4'd3:    days = 9'd122;
         4'd4:    days = 9'd153;
         4'd5:    days = 9'd183;
         4'd6:    days = 9'd214;
         4'd7:    days = 9'd244;
         4'd8:    days = 9'd275;
         4'd9:    days = 9'd306;
         4'd10:   days = 9'd336;
         4'd11:   days = 9'd367;
         4'd12:   days = 9'd397;
         4'd13:   days = 9'd428;
         4'd14:   days = 9'd459;
         default: days = 9'd489;
      endcase
      return days;
   endfunction

endpackage

### hw/rtl/cdn_core.sv
module cdn_core (
   input  cdn_pkg::date_type   date,
   output cdn_pkg::result_type result
);
   import cdn_pkg::*;

   logic [16:0]        secs_raw;
   logic               carry;
   logic signed [15:0] y_base;
   logic signed [15:0] y;
   logic               early;
   logic               julian;
   logic [5:0]         dom_carry;
   logic [26:0]        century_prod;
   logic [7:0]         century;
   logic signed [9:0]  b;
   logic signed [26:0] year_prod;
   logic signed [26:0] c;
   logic signed [26:0] sum;

   assign secs_raw = 17'(date.hour) * SecondsPerHour
                   + 17'(date.minute) * SecondsPerMin
                   + 17'(date.second);
   assign carry    = (secs_raw >= SecondsPerDay);

   assign early  = (date.month < MonthMarch);
   assign y_base = (date.year < 0) ? 16'(date.year) + 16'sd1 : 16'(date.year);
   assign y      = early ? y_base - 16'sd1 : y_base;

   assign dom_carry = {1'b0, date.day_of_month} + {5'd0, carry};
   assign julian = (date.year < GregorianYear) ||
                   ((date.year == GregorianYear) &&
                    ((date.month < GregorianMonth) ||
                     ((date.month == GregorianMonth) && (dom_carry < GregorianDay))));

   // y is positive whenever the correction is applied
   assign century_prod = 27'(y[13:0]) * 27'(CenturyRecip);
   assign century      = century_prod[CenturyShift +: 8];
   assign b = julian ? 10'sd0
                     : 10'sd2 - $signed({2'b00, century}) + $signed({4'b0000, century[7:2]});

   // truncation of (1461y - 3)/4 for negative y equals floor(1461y/4)
   assign year_prod = 27'(y) * QuarterDaysPerYear;
   assign c         = (year_prod >>> 2) - EpochOffset;

   assign sum = c + 27'(b)
              + $signed({18'd0, month_days(date.month)})
              + $signed({22'd0, date.day_of_month})
              + $signed({26'd0, carry});

   always_comb begin
      priority if (sum > WholeDaysMax) begin
         result.whole_days = WholeDaysMax[22:0];
      end else if (sum < WholeDaysMin) begin
         result.whole_days = WholeDaysMin[22:0];
      end else begin
         result.whole_days = sum[22:0];
      end
      result.day_seconds = carry ? secs_raw - SecondsPerDay : secs_raw;
   end

endmodule

### hw/rtl/calendar_to_day_number.sv
// Calendar date and UTC time to day number from 1899 Dec 31 midnight.
// An accepted request beat goes to its response beat through the input
// register, then the result register after one pass of conversion logic.
// Throughput: one beat per cycle while the response side does not stall, set by the two-stage register pipeline.
// Reset clears both stage valid flags; payload registers are not reset.
module calendar_to_day_number (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cdn_pkg::year_type        req_year,
   input  cdn_pkg::month_type       req_month,
   input  cdn_pkg::dom_type         req_day_of_month,
   input  cdn_pkg::hour_type        req_hour,
   input  cdn_pkg::minute_type      req_minute,
   input  cdn_pkg::second_type      req_second,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cdn_pkg::whole_days_type  rsp_whole_days,
   output cdn_pkg::day_seconds_type rsp_day_seconds
);
   import cdn_pkg::*;

   date_type   date_in;
   date_type   date_ff;
   result_type result_in;
   result_type result_ff;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       advance;
   logic       load_in;

   assign date_in = '{year:         req_year,
                      month:        req_month,
                      day_of_month: req_day_of_month,
                      hour:         req_hour,
                      minute:       req_minute,
                      second:       req_second};

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign load_in   = req_valid && !req_stall;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   cdn_core u_core (
      .date   (date_ff),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         date_ff <= date_in;
      end
      if (advance && in_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_whole_days  = result_ff.whole_days;
   assign rsp_day_seconds = result_ff.day_seconds;

   a_secs_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (result_ff.day_seconds < SecondsPerDay))
      else $error("day_seconds out of range");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall without a held beat");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      load_in |=> in_valid_ff)
      else $error("accepted beat lost in input stage");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> rsp_valid_ff)
      else $error("beat lost between stages");

endmodule

### verif/calendar_to_day_number_tb.sv
module calendar_to_day_number_tb;
   import cdn_pkg::*;

   localparam int    DirectedCount = 25;
   localparam int    RandomItems   = 700;
   localparam int    IdleLimit     = 1000;
   localparam int    HoldCycles    = 64;
   localparam int    DrainCycles   = 8;
   localparam int    HoldAtItem    = 200;
   localparam int    PauseAtItem   = 450;
   localparam longint DaySeconds   = 86400;
   localparam longint EpochDays    = 694025;
   localparam longint DaysMax      = 4194303;
   localparam longint DaysMin      = -4194304;
   localparam longint ReformYear   = 1582;
   localparam longint ReformMonth  = 10;
   localparam longint ReformDay    = 15;

   typedef struct packed {
      year_type        year;
      month_type       month;
      dom_type         dom;
      hour_type        hour;
      minute_type      minute;
      second_type      second;
      logic            known;
      whole_days_type  days;
      day_seconds_type secs;
   } vector_type;

   logic            clock;
   logic            reset            = 1'b1;
   logic            req_valid        = 1'b0;
   logic            req_stall;
   year_type        req_year         = '0;
   month_type       req_month        = '0;
   dom_type         req_day_of_month = '0;
   hour_type        req_hour         = '0;
   minute_type      req_minute       = '0;
   second_type      req_second       = '0;
   logic            rsp_valid;
   logic            rsp_stall        = 1'b1;
   whole_days_type  rsp_whole_days;
   day_seconds_type rsp_day_seconds;

   result_type due_day_numbers [$];
   int         failures     = 0;
   bit         send_burst   = 1'b0;
   bit         take_burst   = 1'b0;
   bit         hold_request = 1'b0;
   int         take_wait    = 0;

   // year, month, day, hour, minute, second, known, whole_days, day_seconds
   vector_type directed_rows [DirectedCount] = '{
      '{1899, 12, 31, 12,  0,  0, 1,        0, 43200},  // epoch
      '{1899, 12, 31,  0,  0,  0, 1,        0,     0},
      '{16383, 15, 31, 31, 63, 63, 1, 4194303, 29043},  // clamps high
      '{-16384, 0,  0,  0,  0,  0, 1, -4194304,    0},  // clamps low
      '{-4712,  1,  1, 12,  0,  0, 0, 0, 0},
      '{9999,  12, 31, 23, 59, 59, 0, 0, 0},
      '{1582,  10,  4, 23, 59, 59, 0, 0, 0},
      '{1582,  10, 15,  0,  0,  0, 0, 0, 0},
      '{1582,  10, 14, 23, 59, 59, 0, 0, 0},
      '{1582,  10, 14, 31,  0,  0, 0, 0, 0},  // carried day reaches reform
      '{1582,   9, 30,  0,  0,  0, 0, 0, 0},
      '{1582,  11,  1,  0,  0,  0, 0, 0, 0},
      '{1581,  12, 31,  0,  0,  0, 0, 0, 0},
      '{1583,   1,  1,  0,  0,  0, 0, 0, 0},
      '{2000,   0,  1,  0,  0,  0, 0, 0, 0},
      '{2000,  13,  1,  0,  0,  0, 0, 0, 0},
      '{2000,  14,  1,  0,  0,  0, 0, 0, 0},
      '{2000,  15,  1,  0,  0,  0, 0, 0, 0},
      '{2000,   2,  0,  0,  0,  0, 0, 0, 0},
      '{-1,     1,  1,  0,  0,  0, 0, 0, 0},
      '{0,      3,  1,  6, 30, 15, 0, 0, 0},
      '{-1,    12, 31, 23, 59, 59, 0, 0, 0},
      '{1600,   2, 29,  0,  0,  0, 0, 0, 0},
      '{1700,   3,  1,  0,  0,  0, 0, 0, 0},
      '{1970,   1,  1, 24,  0,  0, 0, 0, 0}
   };

   calendar_to_day_number uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_year         (req_year),
      .req_month        (req_month),
      .req_day_of_month (req_day_of_month),
      .req_hour         (req_hour),
      .req_minute       (req_minute),
      .req_second       (req_second),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_whole_days   (rsp_whole_days),
      .rsp_day_seconds  (rsp_day_seconds)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic result_type day_number_of(input date_type dt);
      longint     yr, mo, dom, secs, carry, y, m, a, reform, yterm, mterm, w;
      bit         julian;
      result_type r;
      yr    = longint'($signed(dt.year));
      mo    = dt.month;
      dom   = dt.day_of_month;
      secs  = longint'(dt.hour) * 3600 + longint'(dt.minute) * 60 + longint'(dt.second);
      carry = secs / DaySeconds;
      secs  = secs % DaySeconds;
      y = (yr < 0) ? yr + 1 : yr;
      m = mo;
      if (mo < 3) begin
         m = m + 12;
         y = y - 1;
      end
      julian = (yr < ReformYear) ||
               (yr == ReformYear && (mo < ReformMonth ||
                                     (mo == ReformMonth && dom + carry < ReformDay)));
      if (julian) begin
         reform = 0;
      end else begin
         a      = y / 100;
         reform = 2 - a + a / 4;
      end
      if (y < 0) yterm = (1461 * y - 3) / 4;
      else       yterm = (1461 * y) / 4;
      yterm = yterm - EpochDays;
      mterm = (306001 * (m + 1)) / 10000;
      w = reform + yterm + mterm + dom + carry;
      if (w > DaysMax) w = DaysMax;
      if (w < DaysMin) w = DaysMin;
      r.whole_days  = w[22:0];
      r.day_seconds = secs[16:0];
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic offer(input date_type dt, input bit known, input result_type want);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_year         <= dt.year;
      req_month        <= dt.month;
      req_day_of_month <= dt.day_of_month;
      req_hour         <= dt.hour;
      req_minute       <= dt.minute;
      req_second       <= dt.second;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due_day_numbers.push_back(known ? want : day_number_of(dt));
      @(negedge clock);
   endtask

   task automatic draw_date(output date_type dt);
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         dt.year         = 15'($urandom_range(0, 14711) - 4712);
         dt.month        = 4'($urandom_range(1, 12));
         dt.day_of_month = 5'($urandom_range(1, 31));
         dt.hour         = 5'($urandom_range(0, 23));
         dt.minute       = 6'($urandom_range(0, 59));
         dt.second       = 6'($urandom_range(0, 59));
      end else if (kind < 8) begin
         // around the calendar reform, with overlong times of day
         dt.year         = 15'($urandom_range(1581, 1583));
         dt.month        = 4'($urandom_range(9, 11));
         dt.day_of_month = 5'($urandom);
         dt.hour         = 5'($urandom);
         dt.minute       = 6'($urandom);
         dt.second       = 6'($urandom);
      end else begin
         dt = date_type'($urandom);
         dt.year = 15'($urandom);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_day_numbers.size() == 0) begin
            failures++;
            $display("%0t: unexpected beat: whole_days %0d day_seconds %0d",
                     $time, $signed(rsp_whole_days), rsp_day_seconds);
         end else begin
            want = due_day_numbers.pop_front();
            if (rsp_whole_days !== want.whole_days) begin
               failures++;
               $display("%0t: whole_days expected %0d actual %0d", $time,
                        $signed(want.whole_days), $signed(rsp_whole_days));
            end
            if (rsp_day_seconds !== want.day_seconds) begin
               failures++;
               $display("%0t: day_seconds expected %0d actual %0d", $time,
                        want.day_seconds, rsp_day_seconds);
            end
         end
         if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
         take_wait = take_burst ? 0 : $urandom_range(0, 15);
      end
   end

   // receiver back-pressure
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HoldCycles;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (take_wait != 0) begin
            take_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IdleLimit) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("calendar_to_day_number test failed");
      $finish;
   end

   initial begin
      date_type   dt;
      result_type want;
      vector_type row;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DirectedCount; i++) begin
         row                = directed_rows[i];
         dt.year            = row.year;
         dt.month           = row.month;
         dt.day_of_month    = row.dom;
         dt.hour            = row.hour;
         dt.minute          = row.minute;
         dt.second          = row.second;
         want.whole_days    = row.days;
         want.day_seconds   = row.secs;
         offer(dt, row.known, want);
      end

      for (int i = 0; i < RandomItems; i++) begin
         if (i == HoldAtItem) begin
            hold_request = 1'b1;
            send_burst   = 1'b1;
         end else if (i == PauseAtItem) begin
            req_valid <= 1'b0;
            while (due_day_numbers.size() != 0) @(posedge clock);
            @(negedge clock);
         end else if (i > HoldAtItem + 20 && $urandom_range(0, 39) == 0) begin
            send_burst = !send_burst;
         end
         draw_date(dt);
         offer(dt, 1'b0, want);
      end
      req_valid <= 1'b0;

      while (due_day_numbers.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (failures == 0) begin
         $display("calendar_to_day_number test passed");
      end else begin
         $display("calendar_to_day_number test failed");
      end
      $finish;
   end

endmodule
